@@ sv/eig2_pkg.sv @@
// shared types, widths and latencies of the 2x2 eigen solver
package eig2_pkg;

	// fixed field widths
	localparam int VAL_W  = 32;                   // q16.16 matrix entries and eigenvalues
	localparam int COMP_W = 16;                   // q1.14 vector components

	// internal datapath widths
	localparam int RAD_W  = 64;                   // square root radicand
	localparam int ROOT_W = RAD_W / 2;            // square root result
	localparam int VEC_W  = 36;                   // raw vector components, signed
	localparam int MAG_W  = VEC_W - 1;            // raw component magnitude
	localparam int NRM_W  = 31;                   // magnitude after range reduction
	localparam int FRAC_W = 14;                   // q1.14 fraction bits
	localparam int NUM_W  = NRM_W + FRAC_W + 1;   // divider numerator
	localparam int Q_W    = FRAC_W + 1;           // divider quotient, up to 1.0

	// latencies in enabled cycles
	localparam int SQRT_LAT = ROOT_W;             // one root bit per stage
	localparam int DIV_LAT  = Q_W;                // one quotient bit per stage
	localparam int NORM_LAT = 4 + SQRT_LAT + 1 + DIV_LAT + 1;

	localparam logic signed [COMP_W-1:0] Q14_ONE = COMP_W'(1) << FRAC_W;

	typedef struct packed {
		logic signed [VAL_W-1:0] m00;
		logic signed [VAL_W-1:0] m01;
		logic signed [VAL_W-1:0] m10;
		logic signed [VAL_W-1:0] m11;
	} mat_t;

	typedef struct packed {
		logic signed [VAL_W-1:0]  lambda_first;
		logic signed [COMP_W-1:0] first_vec_x;
		logic signed [COMP_W-1:0] first_vec_y;
		logic signed [VAL_W-1:0]  lambda_second;
		logic signed [COMP_W-1:0] second_vec_x;
		logic signed [COMP_W-1:0] second_vec_y;
	} eig_t;

endpackage

@@ sv/eig2_isqrt.sv @@
// pipelined integer square root, one root bit per stage
module eig2_isqrt import eig2_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [RAD_W-1:0]  rad,
	output logic [ROOT_W-1:0] root
);

	localparam int REM_W = ROOT_W + 2;

	logic [RAD_W-1:0]  rad_s  [SQRT_LAT-1];
	logic [REM_W-1:0]  rem_s  [SQRT_LAT-1];
	logic [ROOT_W-1:0] root_s [SQRT_LAT];

	for (genvar k = 0; k < SQRT_LAT; k++) begin : g_stage
		logic [RAD_W-1:0]  rad_in;
		logic [REM_W-1:0]  rem_in;
		logic [ROOT_W-1:0] root_in;
		logic [REM_W+1:0]  cur;
		logic [REM_W+1:0]  trial;
		logic              take;

		if (k == 0) begin : g_first
			assign rad_in  = rad;
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign rad_in  = rad_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
		end

		// bring down the next bit pair, try root*4+1
		assign cur   = {rem_in, rad_in[RAD_W-1 -: 2]};
		assign trial = {{(REM_W-ROOT_W){1'b0}}, root_in, 2'b01};
		assign take  = (cur >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[k] <= {root_in[ROOT_W-2:0], take};
			end
		end

		if (k < SQRT_LAT - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rad_s[k] <= rad_in << 2;
					rem_s[k] <= take ? REM_W'(cur - trial) : REM_W'(cur);
				end
			end
		end
	end

	assign root = root_s[SQRT_LAT-1];

endmodule

@@ sv/eig2_div.sv @@
// pipelined restoring divider, one quotient bit per stage
module eig2_div import eig2_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [NUM_W-1:0]  num,
	input  logic [ROOT_W-1:0] den,
	output logic [Q_W-1:0]    quo
);

	logic [NUM_W-1:0]  rem_s [DIV_LAT-1];
	logic [ROOT_W-1:0] den_s [DIV_LAT-1];
	logic [Q_W-1:0]    q_s   [DIV_LAT];

	for (genvar k = 0; k < DIV_LAT; k++) begin : g_stage
		localparam int            BIT  = Q_W - 1 - k;
		localparam logic [Q_W-1:0] QBIT = Q_W'(1) << BIT;

		logic [NUM_W-1:0]  rem_in;
		logic [ROOT_W-1:0] den_in;
		logic [Q_W-1:0]    q_in;
		logic [NUM_W:0]    trial;
		logic [NUM_W:0]    rx;
		logic              take;

		if (k == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign q_in   = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign q_in   = q_s[k-1];
		end

		assign trial = {{(NUM_W+1-ROOT_W){1'b0}}, den_in} << BIT;
		assign rx    = {1'b0, rem_in};
		assign take  = (rx >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[k] <= take ? (q_in | QBIT) : q_in;
			end
		end

		if (k < DIV_LAT - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= take ? NUM_W'(rx - trial) : rem_in;
					den_s[k] <= den_in;
				end
			end
		end
	end

	assign quo = q_s[DIV_LAT-1];

endmodule

@@ sv/eig2_norm.sv @@
// scales one raw vector to unit length in q1.14
module eig2_norm import eig2_pkg::*; (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [VEC_W-1:0]  x,
	input  logic signed [VEC_W-1:0]  y,
	output logic signed [COMP_W-1:0] ox,
	output logic signed [COMP_W-1:0] oy
);

	typedef struct packed {
		logic             sx;
		logic             sy;
		logic [NRM_W-1:0] nx;
		logic [NRM_W-1:0] ny;
	} nside_t;

	logic [MAG_W-1:0]    mx_s1, my_s1;
	logic                sx_s1, sy_s1;
	logic [MAG_W-1:0]    mor;
	logic [2:0]          sh;
	logic [VEC_W-1:0]    nx_x, ny_x;
	nside_t              side_s2, side_s3, side_s4;
	nside_t              side_dly [SQRT_LAT];
	logic [2*NRM_W-1:0]  sqx_s3, sqy_s3;
	logic [RAD_W-1:0]    sum_s4;
	logic [ROOT_W-1:0]   n_root;
	nside_t              side_r;
	logic [NUM_W-1:0]    numx_s5, numy_s5;
	logic [ROOT_W-1:0]   den_s5;
	logic [1:0]          sgn_s5;
	logic [1:0]          sgn_dly [DIV_LAT];
	logic [Q_W-1:0]      qx, qy;

	// magnitudes and signs
	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1 <= x[VEC_W-1] ? MAG_W'(-x) : MAG_W'(x);
			my_s1 <= y[VEC_W-1] ? MAG_W'(-y) : MAG_W'(y);
			sx_s1 <= x[VEC_W-1];
			sy_s1 <= y[VEC_W-1];
		end
	end

	// shift both right until each fits in NRM_W bits
	assign mor = mx_s1 | my_s1;

	always_comb begin
		if (mor[NRM_W+3])      sh = 3'd4;
		else if (mor[NRM_W+2]) sh = 3'd3;
		else if (mor[NRM_W+1]) sh = 3'd2;
		else if (mor[NRM_W])   sh = 3'd1;
		else                   sh = 3'd0;
	end

	assign nx_x = VEC_W'(mx_s1) >> sh;
	assign ny_x = VEC_W'(my_s1) >> sh;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= '{sx: sx_s1, sy: sy_s1, nx: nx_x[NRM_W-1:0], ny: ny_x[NRM_W-1:0]};
			side_s3 <= side_s2;
			sqx_s3  <= side_s2.nx * side_s2.nx;
			sqy_s3  <= side_s2.ny * side_s2.ny;
			side_s4 <= side_s3;
			sum_s4  <= RAD_W'(sqx_s3) + RAD_W'(sqy_s3);
		end
	end

	eig2_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.rad  (sum_s4),
		.root (n_root)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side_dly[0] <= side_s4;
			for (int i = 1; i < SQRT_LAT; i++) begin
				side_dly[i] <= side_dly[i-1];
			end
		end
	end

	assign side_r = side_dly[SQRT_LAT-1];

	// numerators rounded half up: mag * 2^14 + floor(n/2)
	always_ff @(posedge clk) begin
		if (en) begin
			numx_s5 <= NUM_W'({side_r.nx, {FRAC_W{1'b0}}}) + NUM_W'(n_root >> 1);
			numy_s5 <= NUM_W'({side_r.ny, {FRAC_W{1'b0}}}) + NUM_W'(n_root >> 1);
			den_s5  <= n_root;
			sgn_s5  <= {side_r.sx, side_r.sy};
		end
	end

	eig2_div u_div_x (
		.clk (clk),
		.en  (en),
		.num (numx_s5),
		.den (den_s5),
		.quo (qx)
	);

	eig2_div u_div_y (
		.clk (clk),
		.en  (en),
		.num (numy_s5),
		.den (den_s5),
		.quo (qy)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_dly[0] <= sgn_s5;
			for (int i = 1; i < DIV_LAT; i++) begin
				sgn_dly[i] <= sgn_dly[i-1];
			end
		end
	end

	// restore signs
	always_ff @(posedge clk) begin
		if (en) begin
			ox <= sgn_dly[DIV_LAT-1][1] ? -COMP_W'(qx) : COMP_W'(qx);
			oy <= sgn_dly[DIV_LAT-1][0] ? -COMP_W'(qy) : COMP_W'(qy);
		end
	end

endmodule

@@ sv/eigen_solve_2x2_unit.sv @@
// top level of the closed-form 2x2 eigen solver
//
// usage:
//   mat channel (mat_valid/mat_ready/mat) takes one 2x2 q16.16 matrix per item.
//   eig channel (eig_valid/eig_ready/eig) returns both eigenvalues (q16.16,
//   saturated) and both unit eigenvectors (q1.14) per item, in input order.
//   a matrix whose off-diagonal product is not positive returns its diagonal
//   and the axis vectors.
// timing:
//   fully pipelined, 89 register stages plus the output register.
//   one item per cycle sustained while eig_ready stays high; the pipeline length
//   is set by two bit-serial square roots (32 stages each) and the 15-stage
//   quotient of the normalization.
// reset:
//   arst_n clears all valid bits; the pipeline comes up empty and ready.
// stall:
//   a skid register behind the output register catches the item that is in
//   flight when eig_ready drops; the pipeline then holds (mat_ready low)
//   until the skid register drains, so nothing is lost or repeated.
module eigen_solve_2x2_unit import eig2_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic mat_valid,
	output logic mat_ready,
	input  mat_t mat,
	output logic eig_valid,
	input  logic eig_ready,
	output eig_t eig
);

	localparam int PIPE_LAT = 3 + SQRT_LAT + 1 + NORM_LAT;

	typedef struct packed {
		mat_t                m;
		logic signed [VAL_W:0] e;
		logic signed [VAL_W:0] tr;
		logic                diag;
	} tside_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] l1;
		logic signed [VAL_W-1:0] l2;
		logic                    diag;
	} lside_t;

	logic                    pipe_en;
	logic [PIPE_LAT-1:0]     vld_q;

	// front end
	mat_t                    m_s1, m_s2;
	logic signed [2*VAL_W-1:0] p_s1, p_s2;
	logic signed [VAL_W:0]   e_s1, e_s2, tr_s1, tr_s2;
	logic [VAL_W-1:0]        ue;
	logic [2*VAL_W-1:0]      e2_s2;
	logic                    diag_s2;
	logic [RAD_W-1:0]        rad_s3;
	tside_t                  side_s3;
	tside_t                  side_dly [SQRT_LAT];
	tside_t                  sd;
	logic [ROOT_W-1:0]       s_root;

	// eigenvalues and raw vectors
	logic signed [VEC_W-1:0] two_s, e36, tr36, b2, c2, hi, lo;
	logic signed [VEC_W-1:0] v1x, v1y, v2x, v2y;
	logic signed [VEC_W-1:0] v1x_s4, v1y_s4, v2x_s4, v2y_s4;
	lside_t                  lam_s4;
	lside_t                  lam_dly [NORM_LAT];
	logic signed [COMP_W-1:0] n1x, n1y, n2x, n2y;

	// output side
	eig_t                    res;
	logic                    inc;
	eig_t                    eig_q, skid_q;
	logic                    eig_valid_q, skid_v_q;

	function automatic logic signed [VAL_W-1:0] sat32(input logic signed [VEC_W-1:0] v);
		logic signed [VEC_W-1:0] vmax, vmin;
		vmax = VEC_W'({1'b0, {(VAL_W-1){1'b1}}});
		vmin = -vmax - VEC_W'(1);
		if (v > vmax)      return {1'b0, {(VAL_W-1){1'b1}}};
		else if (v < vmin) return {1'b1, {(VAL_W-1){1'b0}}};
		else               return v[VAL_W-1:0];
	endfunction

	// the whole pipeline moves unless the skid register is occupied
	assign pipe_en   = !skid_v_q;
	assign mat_ready = pipe_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (pipe_en) begin
			vld_q <= {vld_q[PIPE_LAT-2:0], mat_valid};
		end
	end

	// stage 1: off-diagonal product, difference and trace
	always_ff @(posedge clk) begin
		if (pipe_en) begin
			m_s1  <= mat;
			p_s1  <= mat.m01 * mat.m10;
			e_s1  <= (VAL_W+1)'(mat.m00) - (VAL_W+1)'(mat.m11);
			tr_s1 <= (VAL_W+1)'(mat.m00) + (VAL_W+1)'(mat.m11);
		end
	end

	// stage 2: square of the diagonal difference, path decision
	assign ue = e_s1[VAL_W] ? VAL_W'(-e_s1) : VAL_W'(e_s1);

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			m_s2    <= m_s1;
			p_s2    <= p_s1;
			e_s2    <= e_s1;
			tr_s2   <= tr_s1;
			e2_s2   <= ue * ue;
			diag_s2 <= (p_s1 <= 0);
		end
	end

	// stage 3: radicand e*e/4 + b*c
	always_ff @(posedge clk) begin
		if (pipe_en) begin
			rad_s3  <= (e2_s2 >> 2) + $unsigned(p_s2);
			side_s3 <= '{m: m_s2, e: e_s2, tr: tr_s2, diag: diag_s2};
		end
	end

	eig2_isqrt u_isqrt (
		.clk  (clk),
		.en   (pipe_en),
		.rad  (rad_s3),
		.root (s_root)
	);

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			side_dly[0] <= side_s3;
			for (int i = 1; i < SQRT_LAT; i++) begin
				side_dly[i] <= side_dly[i-1];
			end
		end
	end

	assign sd = side_dly[SQRT_LAT-1];

	// stage 4: eigenvalues and closed-form vectors
	assign two_s = $signed({{(VEC_W-ROOT_W-1){1'b0}}, s_root, 1'b0});
	assign e36   = VEC_W'(sd.e);
	assign tr36  = VEC_W'(sd.tr);
	assign b2    = VEC_W'(sd.m.m01) <<< 1;
	assign c2    = VEC_W'(sd.m.m10) <<< 1;
	assign hi    = tr36 + two_s;
	assign lo    = tr36 - two_s;

	always_comb begin
		if (e36 < 0) begin
			v1x = c2;
			v1y = two_s - e36;
			v2x = e36 - two_s;
			v2y = b2;
		end else begin
			v1x = e36 + two_s;
			v1y = b2;
			v2x = c2;
			v2y = -e36 - two_s;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			lam_s4.l1   <= sd.diag ? sd.m.m00 : sat32(hi >>> 1);
			lam_s4.l2   <= sd.diag ? sd.m.m11 : sat32(lo >>> 1);
			lam_s4.diag <= sd.diag;
			v1x_s4      <= v1x;
			v1y_s4      <= v1y;
			v2x_s4      <= v2x;
			v2y_s4      <= v2y;
		end
	end

	eig2_norm u_norm_first (
		.clk (clk),
		.en  (pipe_en),
		.x   (v1x_s4),
		.y   (v1y_s4),
		.ox  (n1x),
		.oy  (n1y)
	);

	eig2_norm u_norm_second (
		.clk (clk),
		.en  (pipe_en),
		.x   (v2x_s4),
		.y   (v2y_s4),
		.ox  (n2x),
		.oy  (n2y)
	);

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			lam_dly[0] <= lam_s4;
			for (int i = 1; i < NORM_LAT; i++) begin
				lam_dly[i] <= lam_dly[i-1];
			end
		end
	end

	// diagonal path overrides the normalized vectors with the axes
	always_comb begin
		res.lambda_first  = lam_dly[NORM_LAT-1].l1;
		res.lambda_second = lam_dly[NORM_LAT-1].l2;
		if (lam_dly[NORM_LAT-1].diag) begin
			res.first_vec_x  = Q14_ONE;
			res.first_vec_y  = '0;
			res.second_vec_x = '0;
			res.second_vec_y = Q14_ONE;
		end else begin
			res.first_vec_x  = n1x;
			res.first_vec_y  = n1y;
			res.second_vec_x = n2x;
			res.second_vec_y = n2y;
		end
	end

	// output register with skid register
	assign inc = vld_q[PIPE_LAT-1] & pipe_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eig_valid_q <= 1'b0;
			skid_v_q    <= 1'b0;
		end else if (!eig_valid_q || eig_ready) begin
			if (skid_v_q) begin
				eig_valid_q <= 1'b1;
				skid_v_q    <= 1'b0;
			end else begin
				eig_valid_q <= inc;
			end
		end else if (inc) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!eig_valid_q || eig_ready) begin
			eig_q <= skid_v_q ? skid_q : res;
		end else if (inc) begin
			skid_q <= res;
		end
	end

	assign eig_valid = eig_valid_q;
	assign eig       = eig_q;

endmodule
